@@ rtl/tta_pkg.sv @@
// Shared types, codes and conversion table arithmetic of the thermistor temperature alarm.
package tta_pkg;

	typedef logic signed [12:0] temp_t;
	typedef logic [19:0]        period_t;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_CLICK  = 2'd1;
	localparam logic [1:0] ACT_SAMPLE = 2'd2;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_HOT   = 2'd1;
	localparam logic [1:0] EV_READY = 2'd2;

	localparam int        CFG_IDX_W       = 3;
	localparam int        CFG_DATA_W      = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READY_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DELTA      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REARM_PERIOD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PERIOD     = 3'd4;

	localparam temp_t   HOT_RESET   = 13'sd1440;
	localparam temp_t   READY_RESET = 13'sd816;
	localparam logic [11:0] DELTA_RESET = 12'd32;
	localparam period_t REARM_RESET = 20'd120000;
	localparam period_t IDLE_RESET  = 20'd300000;

	localparam temp_t TEMP_MIN = -13'sd800;
	localparam temp_t TEMP_MAX = 13'sd2400;

	// Divider resistance and thermistor nominal resistance in ohms.
	localparam logic [31:0] SERIES_OHMS  = 32'd9000;
	localparam logic [31:0] NOMINAL_OHMS = 32'd216000;
	localparam logic [63:0] LN2_Q32      = 64'd2977044472;
	localparam logic [63:0] KNUM         = 64'd19886843520;
	localparam longint      BETA_Q       = 64'sd4168800;
	localparam longint      T0_Q         = 64'sd298150;
	localparam longint      KELVIN_CENTI = 64'sd437040;

	// Base-two logarithm in Q24, fraction bits by repeated squaring of the mantissa.
	function automatic logic [31:0] log2_q24(input logic [31:0] n);
		logic [31:0] k;
		logic [31:0] frac;
		logic [63:0] m;
		k    = 32'd0;
		frac = 32'd0;
		for (int i = 0; i < 32; i++) begin
			if (n[i]) begin
				k = 32'(i);
			end
		end
		if (n == 32'd0) begin
			return 32'd0;
		end
		if (k <= 32'd30) begin
			m = 64'(n) << (32'd30 - k);
		end else begin
			m = 64'(n >> 1);
		end
		for (int i = 0; i < 24; i++) begin
			m    = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m    = m >> 1;
				frac = frac | 32'd1;
			end
		end
		return (k << 24) | frac;
	endfunction

	function automatic longint ln_q20(input logic [31:0] n);
		logic [63:0] p;
		p = 64'(log2_q24(n)) * LN2_Q32 + (64'd1 << 35);
		return longint'(p >> 36);
	endfunction

	// Restoring long division, used only while the conversion table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = 64'd0;
		quo = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Temperature for one averaged converter code, from the beta equation.
	function automatic temp_t conv_entry(input logic [31:0] a, input logic [31:0] full);
		longint      lnr;
		longint      den;
		longint      d;
		logic [63:0] centi;
		if (a == 32'd0 || a >= full) begin
			return TEMP_MIN;
		end
		lnr = ln_q20(SERIES_OHMS * a) - ln_q20(NOMINAL_OHMS * (full - a));
		den = BETA_Q * (64'sd1 <<< 20) + T0_Q * lnr;
		if (den <= 0) begin
			return TEMP_MIN;
		end
		centi = udiv64((KNUM << 20) * 64'd100, 64'(den));
		d = longint'(centi) - KELVIN_CENTI;
		if (d < -64'sd80000) begin
			return TEMP_MIN;
		end
		if (d > 64'sd240000) begin
			return TEMP_MAX;
		end
		return 13'((d + 64'sd80050) / 100 - 64'sd800);
	endfunction

endpackage

@@ rtl/tta_channels.sv @@
// Handshake channels carrying the input items and the result items.
interface tta_item_if #(
	parameter int ADC_BITS = 10
);
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output action, output adc_sample, input ready);
	modport sink   (input valid, input action, input adc_sample, output ready);
endinterface

interface tta_result_if;
	logic          valid;
	logic          ready;
	logic          buzzer_drive;
	logic          power_hold;
	logic          buzzer_enabled;
	logic          temp_valid;
	tta_pkg::temp_t temperature;
	logic [1:0]    alarm_event;

	modport source (output valid, output buzzer_drive, output power_hold, output buzzer_enabled,
		output temp_valid, output temperature, output alarm_event, input ready);
	modport sink   (input valid, input buzzer_drive, input power_hold, input buzzer_enabled,
		input temp_valid, input temperature, input alarm_event, output ready);
endinterface

@@ rtl/thermistor_temperature_alarm.sv @@
// Thermistor temperature alarm: two-stage pipeline with registered result.
// The block takes one transaction every clock cycle when the result side keeps up, and each
// result passes through the stage-one registers and then into the result register. The first
// stage adds a converter
// sample into the running sum, divides the sum by the burst length with a reciprocal multiply
// and reads the conversion table into a register; the table holds one entry per converter code
// and is built from the beta equation when the design is elaborated. The second stage applies
// timers, button toggles, alarm thresholds and the idle check in item order and loads the
// result register, which doubles as the buzzer, power and enable state. A full result register
// that is not taken stalls the first stage and then the input.
module thermistor_temperature_alarm #(
	parameter int SAMPLES_PER_READING = 20,
	parameter int ADC_BITS            = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tta_item_if.sink                        item,
	tta_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [tta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tta_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int ROM_SIZE = 1 << ADC_BITS;
	localparam int CNT_W    = $clog2(SAMPLES_PER_READING + 1);
	localparam int SUM_W    = ADC_BITS + $clog2(SAMPLES_PER_READING);
	localparam int RECIP_S  = SUM_W + $clog2(SAMPLES_PER_READING);
	localparam logic [RECIP_S:0] RECIP_M =
		(RECIP_S + 1)'(((64'd1 << RECIP_S) + 64'(SAMPLES_PER_READING) - 64'd1)
		/ 64'(SAMPLES_PER_READING));
	localparam int PROD_W   = SUM_W + RECIP_S + 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

	typedef tta_pkg::temp_t rom_t [ROM_SIZE];

	function automatic rom_t build_rom();
		rom_t r;
		for (int a = 0; a < ROM_SIZE; a++) begin
			r[a] = tta_pkg::conv_entry(32'(a), 32'(ROM_SIZE - 1));
		end
		return r;
	endfunction

	localparam rom_t CONV_ROM = build_rom();

	// Configuration registers.
	tta_pkg::temp_t  hot_threshold_q;
	tta_pkg::temp_t  ready_threshold_q;
	logic [11:0]     idle_delta_q;
	tta_pkg::period_t rearm_period_q;
	tta_pkg::period_t idle_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_threshold_q   <= tta_pkg::HOT_RESET;
			ready_threshold_q <= tta_pkg::READY_RESET;
			idle_delta_q      <= tta_pkg::DELTA_RESET;
			rearm_period_q    <= tta_pkg::REARM_RESET;
			idle_period_q     <= tta_pkg::IDLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tta_pkg::CFG_HOT_THRESHOLD:   hot_threshold_q   <= cfg_data[12:0];
				tta_pkg::CFG_READY_THRESHOLD: ready_threshold_q <= cfg_data[12:0];
				tta_pkg::CFG_IDLE_DELTA:      idle_delta_q      <= cfg_data[11:0];
				tta_pkg::CFG_REARM_PERIOD:    rearm_period_q    <= cfg_data;
				tta_pkg::CFG_IDLE_PERIOD:     idle_period_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake between the stages.
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic accept;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;

	// Stage one: accumulate and look up.
	logic [SUM_W-1:0]    sample_sum_q;
	logic [CNT_W-1:0]    sample_count_q;
	logic [SUM_W-1:0]    sum_next;
	logic [PROD_W-1:0]   recip_prod;
	logic [ADC_BITS-1:0] avg;
	logic                reading_done;
	logic                is_sample;

	assign is_sample    = (item.action == tta_pkg::ACT_SAMPLE);
	assign reading_done = is_sample && (sample_count_q == CNT_LAST);
	assign sum_next     = sample_sum_q + SUM_W'(item.adc_sample);
	assign recip_prod   = PROD_W'(sum_next) * PROD_W'(RECIP_M);
	assign avg          = recip_prod[RECIP_S +: ADC_BITS];

	logic [1:0]     action_s1;
	logic           done_s1;
	tta_pkg::temp_t rom_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			sample_sum_q   <= '0;
			sample_count_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (accept && is_sample) begin
				if (reading_done) begin
					sample_sum_q   <= '0;
					sample_count_q <= '0;
				end else begin
					sample_sum_q   <= sum_next;
					sample_count_q <= sample_count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= item.action;
			done_s1   <= reading_done;
			rom_s1    <= CONV_ROM[avg];
		end
	end

	// Stage two: state update in item order, result register.
	logic             buzzer_level_q;
	logic             power_keep_q;
	logic             enable_q;
	logic             warmed_up_q;
	logic             first_idle_q;
	tta_pkg::temp_t   last_temp_q;
	tta_pkg::temp_t   prev_idle_temp_q;
	tta_pkg::period_t rearm_timer_q;
	tta_pkg::period_t idle_timer_q;
	logic             temp_valid_q;
	logic [1:0]       event_q;

	logic             level_d;
	logic             power_d;
	logic             enable_d;
	logic             warmed_d;
	logic             first_d;
	tta_pkg::temp_t   last_temp_d;
	tta_pkg::temp_t   prev_temp_d;
	tta_pkg::period_t rearm_d;
	tta_pkg::period_t idle_d;
	tta_pkg::period_t rearm_inc;
	tta_pkg::period_t idle_inc;
	logic             tvalid_d;
	logic [1:0]       event_d;
	logic signed [13:0] temp_diff;
	logic [13:0]      temp_dist;

	assign rearm_inc = (rearm_timer_q == '1) ? rearm_timer_q : rearm_timer_q + 20'd1;
	assign idle_inc  = (idle_timer_q == '1) ? idle_timer_q : idle_timer_q + 20'd1;
	assign temp_diff = 14'(rom_s1) - 14'(prev_idle_temp_q);
	assign temp_dist = temp_diff[13] ? 14'(-temp_diff) : 14'(temp_diff);

	always_comb begin
		level_d     = buzzer_level_q;
		power_d     = power_keep_q;
		enable_d    = enable_q;
		warmed_d    = warmed_up_q;
		first_d     = first_idle_q;
		last_temp_d = last_temp_q;
		prev_temp_d = prev_idle_temp_q;
		rearm_d     = rearm_timer_q;
		idle_d      = idle_timer_q;
		tvalid_d    = 1'b0;
		event_d     = tta_pkg::EV_NONE;
		case (action_s1)
			tta_pkg::ACT_TICK: begin
				idle_d = idle_inc;
				if (rearm_inc >= rearm_period_q) begin
					rearm_d  = '0;
					enable_d = 1'b1;
				end else begin
					rearm_d = rearm_inc;
				end
			end
			tta_pkg::ACT_CLICK: begin
				enable_d = !enable_q;
			end
			tta_pkg::ACT_SAMPLE: begin
				if (done_s1) begin
					last_temp_d = rom_s1;
					tvalid_d    = 1'b1;
					if (rom_s1 > hot_threshold_q && enable_q) begin
						level_d  = 1'b1;
						warmed_d = 1'b1;
						event_d  = tta_pkg::EV_HOT;
					end else if (warmed_up_q && rom_s1 < ready_threshold_q && enable_q) begin
						level_d = 1'b1;
						event_d = tta_pkg::EV_READY;
					end
					if (idle_timer_q >= idle_period_q) begin
						idle_d = '0;
						if (!first_idle_q && temp_dist <= 14'(idle_delta_q)) begin
							power_d = 1'b0;
						end
						first_d     = 1'b0;
						prev_temp_d = rom_s1;
					end
				end
			end
			default: ;
		endcase
		// A disabled buzzer always silences the output.
		if (!enable_d) begin
			level_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q      <= 1'b0;
			buzzer_level_q   <= 1'b0;
			power_keep_q     <= 1'b1;
			enable_q         <= 1'b1;
			warmed_up_q      <= 1'b0;
			first_idle_q     <= 1'b1;
			last_temp_q      <= '0;
			prev_idle_temp_q <= '0;
			rearm_timer_q    <= '0;
			idle_timer_q     <= '0;
			temp_valid_q     <= 1'b0;
			event_q          <= tta_pkg::EV_NONE;
		end else begin
			if (advance) begin
				out_valid_q      <= 1'b1;
				buzzer_level_q   <= level_d;
				power_keep_q     <= power_d;
				enable_q         <= enable_d;
				warmed_up_q      <= warmed_d;
				first_idle_q     <= first_d;
				last_temp_q      <= last_temp_d;
				prev_idle_temp_q <= prev_temp_d;
				rearm_timer_q    <= rearm_d;
				idle_timer_q     <= idle_d;
				temp_valid_q     <= tvalid_d;
				event_q          <= event_d;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.buzzer_drive   = buzzer_level_q;
	assign result.power_hold     = power_keep_q;
	assign result.buzzer_enabled = enable_q;
	assign result.temp_valid     = temp_valid_q;
	assign result.temperature    = last_temp_q;
	assign result.alarm_event    = event_q;

endmodule
